>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Each takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequence at the same edge as the condition.
`define RPN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rpn_calc: same-cycle check failed");

// Check the consequence at the edge after the condition.
`define RPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rpn_calc: next-cycle check failed");

`endif

>>> rtl/core/rpn_calc_pkg.sv
package rpn_calc_pkg;

	// Port field widths
	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int DEPTH_W  = 5;
	localparam int STATUS_W = 2;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Operation codes
	localparam func_t FUNC_PUSH = 3'd0;
	localparam func_t FUNC_ADD  = 3'd1;
	localparam func_t FUNC_SUB  = 3'd2;
	localparam func_t FUNC_MUL  = 3'd3;
	localparam func_t FUNC_DIV  = 3'd4;
	localparam func_t FUNC_MIN  = 3'd5;

	// Status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_UNDERFLOW = 2'd1;
	localparam status_t ST_DIVZERO   = 2'd2;
	localparam status_t ST_FULL      = 2'd3;

endpackage

>>> rtl/core/rpn_calc_cmd_if.sv
interface rpn_calc_cmd_if;
	import rpn_calc_pkg::*;

	logic                      valid;
	logic                      ready;
	func_t                     func;
	logic signed [VALUE_W-1:0] push_value;

	modport source (output valid, func, push_value, input ready);
	modport sink (input valid, func, push_value, output ready);
endinterface

>>> rtl/core/rpn_calc_rsp_if.sv
interface rpn_calc_rsp_if;
	import rpn_calc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] top_value;
	logic [DEPTH_W-1:0]        stack_depth;
	status_t                   status;

	modport source (output valid, top_value, stack_depth, status, input ready);
	modport sink (input valid, top_value, stack_depth, status, output ready);
endinterface

>>> rtl/core/rpn_stack_calculator_top.sv
// RPN integer stack calculator.
// cmd channel (valid/ready): one item per operation; func selects push, add,
// subtract, multiply, truncating divide or signed minimum; push_value is used
// only by a push. rsp channel (valid/ready): exactly one item per cmd item,
// carrying the top of stack (zero when empty), the entry count and a status
// (ok, too few operands, divide by zero, stack full).
// One item is in flight at a time: cmd.ready is high only while idle.
// Each item is decoded; an operation with enough operands then loads them,
// multiply and divide iterate (divide also fixes the signs before and after),
// and the result is written back before the result register is loaded.
// One shared adder does the arithmetic and runs the shift-add multiply and the
// restoring divide one bit per cycle; the stack memory read is registered.
// Reset (arst_n low) empties the stack and drops any pending result; the
// stack memory itself is not cleared. When the rsp receiver stalls, the
// result holds in the output register; the next item can still be accepted
// and worked, and it waits at its end until the register is free.
module rpn_stack_calculator_top #(
	parameter int STACK_DEPTH = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rpn_calc_cmd_if.sink          cmd,
	rpn_calc_rsp_if.source        rsp
);
	import rpn_calc_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int IW = $clog2(DATA_WIDTH);

	localparam logic [W-1:0]  SIGN_BIT  = {1'b1, {(W-1){1'b0}}};
	localparam logic [IW-1:0] ITER_LAST = IW'(DATA_WIDTH - 1);
	localparam logic [CW-1:0] CNT_FULL  = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] CNT_TWO   = CW'(2);

	// Sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_LOAD   = 4'd2;
	localparam logic [3:0] S_NEGB   = 4'd3;
	localparam logic [3:0] S_ITER   = 4'd4;
	localparam logic [3:0] S_NEGQ   = 4'd5;
	localparam logic [3:0] S_WBACK  = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;

	logic [3:0]          state_q;
	logic [CW-1:0]       count_q;
	logic                out_valid_q;

	func_t               func_q;
	logic [W-1:0]        pv_q;
	logic [W-1:0]        top_q;
	logic [W-1:0]        rd_q;
	logic [W-1:0]        acc_q;
	logic [W-1:0]        opa_q;
	logic [W-1:0]        opb_q;
	logic                neg_q;
	logic [IW-1:0]       iter_q;
	status_t             status_q;

	logic [VALUE_W-1:0]  out_top_q;
	logic [DEPTH_W-1:0]  out_depth_q;
	status_t             out_status_q;

	logic [W-1:0]        stack_mem [STACK_DEPTH];

	logic                accept;
	logic                is_push;
	logic                is_op;
	logic                stack_full;
	logic                too_few;
	logic                div_zero;
	logic                out_load;
	logic [CW-1:0]       cnt_m2;
	logic [AW-1:0]       raddr;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [W-1:0]        mem_wdata;
	logic [63:0]         pv_ext;
	logic [63:0]         top_ext;
	logic [15:0]         cnt_ext;
	logic [W-1:0]        rem_shift;
	logic [W-1:0]        unit_x;
	logic [W-1:0]        unit_y;
	logic                unit_sub;
	logic [W:0]          unit_sum;
	logic                unit_carry;

	// Handshake and decode
	assign accept     = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == S_IDLE);
	assign is_push    = (func_q == FUNC_PUSH);
	assign is_op      = (func_q inside {[FUNC_ADD:FUNC_MIN]});
	assign stack_full = (count_q >= CNT_FULL);
	assign too_few    = (count_q < CNT_TWO);
	assign div_zero   = (top_q == '0);
	assign out_load   = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	// Operand a sits just below the top; the top lives in top_q
	assign cnt_m2 = count_q - CNT_TWO;
	assign raddr  = cnt_m2[AW-1:0];

	// Sign-extend the pushed value to the stack width
	assign pv_ext = {{(64-VALUE_W){cmd.push_value[VALUE_W-1]}}, cmd.push_value};

	// Widen for the fixed-width result fields
	assign top_ext = 64'(top_q);
	assign cnt_ext = 16'(count_q);

	assign rem_shift = {acc_q[W-2:0], opa_q[W-1]};

	// Shared adder operand select
	always_comb begin
		unit_x   = '0;
		unit_y   = '0;
		unit_sub = 1'b0;
		case (state_q)
			S_LOAD: begin
				case (func_q)
					FUNC_ADD: begin
						unit_x = rd_q;
						unit_y = top_q;
					end
					FUNC_SUB: begin
						unit_x   = rd_q;
						unit_y   = top_q;
						unit_sub = 1'b1;
					end
					FUNC_MIN: begin
						// carry set means top >= a, signed
						unit_x   = top_q ^ SIGN_BIT;
						unit_y   = rd_q ^ SIGN_BIT;
						unit_sub = 1'b1;
					end
					FUNC_DIV: begin
						unit_y   = rd_q;
						unit_sub = 1'b1;
					end
					default: begin
						unit_sub = 1'b0;
					end
				endcase
			end
			S_NEGB: begin
				unit_y   = opb_q;
				unit_sub = 1'b1;
			end
			S_ITER: begin
				if (func_q == FUNC_MUL) begin
					unit_x = acc_q;
					unit_y = opa_q[0] ? opb_q : '0;
				end else begin
					unit_x   = rem_shift;
					unit_y   = opb_q;
					unit_sub = 1'b1;
				end
			end
			S_NEGQ: begin
				unit_y   = opa_q;
				unit_sub = 1'b1;
			end
			default: begin
				unit_sub = 1'b0;
			end
		endcase
	end

	assign unit_sum   = {1'b0, unit_x} + {1'b0, unit_y ^ {W{unit_sub}}} + {{W{1'b0}}, unit_sub};
	assign unit_carry = unit_sum[W];

	// Stack memory write select: push in decode, result in write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = pv_q;
		if (state_q == S_DECODE && is_push && !stack_full) begin
			mem_we = 1'b1;
		end else if (state_q == S_WBACK) begin
			mem_we    = 1'b1;
			mem_waddr = raddr;
			mem_wdata = acc_q;
		end
	end

	// Stack memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= stack_mem[raddr];
	end

	// Sequencer, entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (is_push) begin
						if (!stack_full) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_FIN;
					end else if (is_op && !too_few) begin
						state_q <= S_LOAD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LOAD: begin
					case (func_q)
						FUNC_DIV: state_q <= div_zero ? S_FIN : S_NEGB;
						FUNC_MUL: state_q <= S_ITER;
						default:  state_q <= S_WBACK;
					endcase
				end
				S_NEGB: begin
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (iter_q == '0) begin
						state_q <= (func_q == FUNC_MUL) ? S_WBACK : S_NEGQ;
					end
				end
				S_NEGQ: begin
					state_q <= S_WBACK;
				end
				S_WBACK: begin
					count_q <= count_q - CW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q <= cmd.func;
					pv_q   <= pv_ext[W-1:0];
				end
			end
			S_DECODE: begin
				if (is_push) begin
					if (stack_full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
						top_q    <= pv_q;
					end
				end else if (is_op && too_few) begin
					status_q <= ST_UNDERFLOW;
				end else begin
					status_q <= ST_OK;
				end
			end
			S_LOAD: begin
				iter_q <= ITER_LAST;
				case (func_q)
					FUNC_DIV: begin
						if (div_zero) begin
							status_q <= ST_DIVZERO;
						end
						acc_q <= '0;
						opa_q <= rd_q[W-1] ? unit_sum[W-1:0] : rd_q;
						opb_q <= top_q;
						neg_q <= rd_q[W-1] ^ top_q[W-1];
					end
					FUNC_MUL: begin
						acc_q <= '0;
						opa_q <= rd_q;
						opb_q <= top_q;
					end
					FUNC_MIN: begin
						acc_q <= unit_carry ? rd_q : top_q;
					end
					default: begin
						acc_q <= unit_sum[W-1:0];
					end
				endcase
			end
			S_NEGB: begin
				if (opb_q[W-1]) begin
					opb_q <= unit_sum[W-1:0];
				end
			end
			S_ITER: begin
				iter_q <= iter_q - IW'(1);
				if (func_q == FUNC_MUL) begin
					// shift-add: one multiplier bit per cycle
					acc_q <= unit_sum[W-1:0];
					opa_q <= opa_q >> 1;
					opb_q <= opb_q << 1;
				end else begin
					// restoring divide: one quotient bit per cycle
					acc_q <= unit_carry ? unit_sum[W-1:0] : rem_shift;
					opa_q <= {opa_q[W-2:0], unit_carry};
				end
			end
			S_NEGQ: begin
				acc_q <= neg_q ? unit_sum[W-1:0] : opa_q;
			end
			S_WBACK: begin
				top_q <= acc_q;
			end
			default: begin
				iter_q <= iter_q;
			end
		endcase

		// Load the result register
		if (out_load) begin
			out_top_q    <= (count_q == '0) ? '0 : top_ext[VALUE_W-1:0];
			out_depth_q  <= cnt_ext[DEPTH_W-1:0];
			out_status_q <= status_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.top_value   = out_top_q;
	assign rsp.stack_depth = out_depth_q;
	assign rsp.status      = out_status_q;

endmodule

>>> rtl/core/rpn_calc_checker.sv
`include "assert_macros.svh"

module rpn_calc_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cmd_valid,
	input  logic                                     cmd_ready,
	input  logic                                     rsp_valid,
	input  logic                                     rsp_ready,
	input  logic [rpn_calc_pkg::VALUE_W-1:0]         rsp_top_value,
	input  logic [rpn_calc_pkg::DEPTH_W-1:0]         rsp_stack_depth,
	input  rpn_calc_pkg::status_t                    rsp_status
);
	import rpn_calc_pkg::*;

	logic [VALUE_W+DEPTH_W+STATUS_W-1:0] rsp_payload;

	assign rsp_payload = {rsp_top_value, rsp_stack_depth, rsp_status};

	// Hold a stalled result
	`RPN_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`RPN_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_payload))

	// Take one item at a time: ready drops right after an accept
	`RPN_ASSERT_NEXT(a_one_in_flight, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)

	// Flag too few operands only with fewer than two entries
	`RPN_ASSERT_NOW(a_underflow_depth, clk, arst_n, rsp_valid && rsp_status == ST_UNDERFLOW, rsp_stack_depth < 5'd2)

endmodule

bind rpn_stack_calculator_top rpn_calc_checker u_rpn_calc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_top_value   (rsp.top_value),
	.rsp_stack_depth (rsp.stack_depth),
	.rsp_status      (rsp.status)
);

>>> verif/tb_top.sv
module tb_top;
	import rpn_calc_pkg::*;

	localparam int STACK_SLOTS = 16;
	localparam int IDLE_PCT    = 37;
	localparam int TAIL_CYCLES = 60;
	localparam int DRAIN_LIMIT = 5000;

	// Codes past the last operation; the block treats them as no-ops
	localparam func_t FUNC_UNUSED_A = 3'd6;
	localparam func_t FUNC_UNUSED_B = 3'd7;

	localparam logic [VALUE_W-1:0] INT_MAX = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] INT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [VALUE_W-1:0] top_value;
		logic [DEPTH_W-1:0] stack_depth;
		status_t            status;
	} calc_result_t;

	logic clk;
	logic arst_n;

	rpn_calc_cmd_if cmd_bus();
	rpn_calc_rsp_if rsp_bus();

	rpn_stack_calculator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// Shadow copy of the calculator stack
	logic [VALUE_W-1:0] shadow_stack [STACK_SLOTS];
	int                 shadow_count;

	calc_result_t pending_results[$];
	int           fail_count;
	bit           idle_on;
	int           hold_request;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run one operation on the shadow stack and queue the result it gives
	task automatic apply_rpn_op(input func_t f, input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] a;
		logic [VALUE_W-1:0] b;
		logic [VALUE_W-1:0] r;
		longint             quot;
		status_t            st;
		bit                 done;
		calc_result_t       res;
		st   = ST_OK;
		done = 1'b1;
		r    = '0;
		if (f == FUNC_PUSH) begin
			if (shadow_count >= STACK_SLOTS) begin
				st = ST_FULL;
			end else begin
				shadow_stack[shadow_count] = v;
				shadow_count++;
			end
		end else if (f == FUNC_ADD || f == FUNC_SUB || f == FUNC_MUL ||
				f == FUNC_DIV || f == FUNC_MIN) begin
			if (shadow_count < 2) begin
				st = ST_UNDERFLOW;
			end else begin
				a = shadow_stack[shadow_count-2];
				b = shadow_stack[shadow_count-1];
				case (f)
					FUNC_ADD: r = a + b;
					FUNC_SUB: r = a - b;
					FUNC_MUL: r = a * b;
					FUNC_DIV: begin
						if (b == '0) begin
							st   = ST_DIVZERO;
							done = 1'b0;
						end else begin
							// 64-bit quotient keeps MIN / -1 defined; keep low bits
							quot = longint'($signed(a)) / longint'($signed(b));
							r    = quot[VALUE_W-1:0];
						end
					end
					default: r = ($signed(a) <= $signed(b)) ? a : b;
				endcase
				if (done) begin
					shadow_count--;
					shadow_stack[shadow_count-1] = r;
				end
			end
		end
		res.top_value   = (shadow_count > 0) ? shadow_stack[shadow_count-1] : '0;
		res.stack_depth = DEPTH_W'(shadow_count);
		res.status      = st;
		pending_results.insert(pending_results.size(), res);
	endtask

	// Offer one item, hold it until accepted, then predict its result
	task automatic send_item(input func_t f, input logic [VALUE_W-1:0] v);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid      <= 1'b1;
		cmd_bus.func       <= f;
		cmd_bus.push_value <= v;
		do @(posedge clk); while (!cmd_bus.ready);
		apply_rpn_op(f, v);
	endtask

	// Hold the sender until every queued result has come back
	task automatic wait_drained();
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_operand();
		case ($urandom_range(9))
			0: return INT_MAX;
			1: return INT_MIN;
			2: return '0;
			3: return '1;
			4, 5: return VALUE_W'($urandom_range(8)) - VALUE_W'(4);
			default: return $urandom;
		endcase
	endfunction

	function automatic func_t pick_func(input int push_pct);
		if ($urandom_range(99) < push_pct)
			return FUNC_PUSH;
		if ($urandom_range(24) == 0)
			return $urandom_range(1) ? FUNC_UNUSED_A : FUNC_UNUSED_B;
		return func_t'($urandom_range(FUNC_MIN, FUNC_ADD));
	endfunction

	// Operand edges, wraparound, zero divisor, MIN / -1, unused codes
	task automatic test_directed_ops();
		send_item(FUNC_ADD, '0);
		send_item(FUNC_UNUSED_A, 32'hDEAD_BEEF);
		send_item(FUNC_PUSH, INT_MAX);
		send_item(FUNC_SUB, '0);
		send_item(FUNC_PUSH, INT_MAX);
		send_item(FUNC_ADD, '0);
		send_item(FUNC_PUSH, INT_MIN);
		send_item(FUNC_MUL, '0);
		send_item(FUNC_PUSH, '0);
		send_item(FUNC_DIV, '1);
		send_item(FUNC_UNUSED_B, '1);
		send_item(FUNC_PUSH, INT_MIN);
		send_item(FUNC_PUSH, '1);
		send_item(FUNC_DIV, '0);
		send_item(FUNC_PUSH, 32'd7);
		send_item(FUNC_MIN, '0);
		send_item(FUNC_PUSH, -32'sd7);
		send_item(FUNC_PUSH, 32'd2);
		send_item(FUNC_DIV, '0);
		send_item(FUNC_MIN, '0);
		send_item(FUNC_SUB, '0);
	endtask

	// Fill to the top, push once more, then fold the stack back down
	task automatic test_stack_full();
		while (shadow_count < STACK_SLOTS)
			send_item(FUNC_PUSH, pick_operand());
		send_item(FUNC_PUSH, INT_MAX);
		while (shadow_count > 2)
			send_item(func_t'($urandom_range(FUNC_MIN, FUNC_ADD)), '0);
	endtask

	task automatic test_random_walk(input int n, input int push_pct);
		repeat (n) send_item(pick_func(push_pct), pick_operand());
	endtask

	task automatic test_no_idle(input int n);
		idle_on = 1'b0;
		test_random_walk(n, 55);
		idle_on = 1'b1;
	endtask

	// Stall the receiver long enough that the input stalls behind it
	task automatic test_backpressure();
		idle_on      = 1'b0;
		hold_request = 400;
		test_random_walk(24, 55);
		idle_on = 1'b1;
		wait_drained();
	endtask

	// Check each result against the oldest prediction; drive rsp ready
	initial begin
		calc_result_t want;
		int           hold_left;
		hold_left     = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: top_value %0d stack_depth %0d status %0d",
						rsp_bus.top_value, rsp_bus.stack_depth, rsp_bus.status);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_bus.top_value !== want.top_value) begin
						$error("top_value: expected %0d, got %0d",
							$signed(want.top_value), rsp_bus.top_value);
						fail_count++;
					end
					if (rsp_bus.stack_depth !== want.stack_depth) begin
						$error("stack_depth: expected %0d, got %0d",
							want.stack_depth, rsp_bus.stack_depth);
						fail_count++;
					end
					if (rsp_bus.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
						fail_count++;
					end
				end
			end
			if (hold_left == 0 && hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= !idle_on || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	initial begin
		int waited;
		fail_count         = 0;
		idle_on            = 1'b1;
		hold_request       = 0;
		shadow_count       = 0;
		clk                = 1'b0;
		arst_n             = 1'b0;
		cmd_bus.valid      <= 1'b0;
		cmd_bus.func       <= FUNC_PUSH;
		cmd_bus.push_value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_stack_full();
		test_random_walk(280, 55);
		test_random_walk(250, 75);
		wait_drained();
		test_random_walk(250, 35);
		test_backpressure();
		test_no_idle(200);
		test_random_walk(200, 60);

		// Let the last results come back, then give stray ones time to show
		cmd_bus.valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
